// ----- src/fpa_pkg.sv -----
package fpa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned DIV_STEPS     = 32;

  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  typedef enum logic [3:0] {
    MODE_ADD  = 4'd0,
    MODE_SUB  = 4'd1,
    MODE_MUL  = 4'd2,
    MODE_DIV  = 4'd3,
    MODE_CMP  = 4'd4,
    MODE_MIN  = 4'd5,
    MODE_MAX  = 4'd6,
    MODE_INC  = 4'd7,
    MODE_DEC  = 4'd8,
    MODE_ITOF = 4'd9,
    MODE_FTOI = 4'd10
  } mode_t;

  // input register stage
  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
  } s1_t;

  // after simple ops and the magnitude multiply
  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] res;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               sat;
    logic               dz;
    logic [63:0]        prod;
    logic               neg;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
  } s2_t;

  // divider pipeline payload
  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] res;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               sat;
    logic               dz;
    logic               neg;
    logic               ovf;
    logic [31:0]        d;
    logic [31:0]        rem;
    logic [31:0]        lo;
    logic [31:0]        q;
  } div_t;

endpackage

// ----- src/fpa_if.sv -----
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               is_less;
  logic               is_equal;
  logic               is_greater;
  logic               saturated;
  logic               divide_by_zero;

  modport source (output valid, result, is_less, is_equal, is_greater, saturated,
                  divide_by_zero, input ready);
  modport sink   (input valid, result, is_less, is_equal, is_greater, saturated,
                  divide_by_zero, output ready);
endinterface

// ----- src/fixed_point_alu.sv -----
// Fixed-point ALU on signed 32-bit raw values with FRAC_BITS fraction bits.
// Input channel in_ch carries a request: mode, operand_a, operand_b. The
// output channel out_ch carries one result per request: result and the
// flags is_less, is_equal, is_greater, saturated, divide_by_zero.
// Both channels use valid/ready; a transfer happens when both are high.
//
// Throughput: one request per cycle while the output is not stalled. The
// depth is set by the divider, a chain of 32 restoring stages producing one
// quotient bit each; the other modes ride along in the same pipeline so
// results leave in request order.
// Stages: input register, multiply and simple ops, rounding of the product
// and divider setup, 32 divider stages, final rounding / clamping register.
//
// When out_ch.ready is low while a result is held, the whole pipeline
// freezes and in_ch.ready drops; nothing is lost or repeated. Empty slots
// do not stall. Reset (rst_n low, synchronous) clears all valid bits.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch
);

  localparam int unsigned NW = 32 + FRAC_BITS;

  // global advance: last register empty or being drained
  logic en;
  logic out_v_r;
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // saturating 32-bit add, returns {sat, sum}
  function automatic logic [32:0] sat_add(input logic signed [31:0] x,
                                          input logic signed [31:0] y);
    logic signed [32:0] s;
    logic               ov;
    s  = {x[31], x} + {y[31], y};
    ov = s[32] != s[31];
    if (ov) begin
      return {1'b1, (s[32] ? fpa_pkg::MIN32 : fpa_pkg::MAX32)};
    end
    return {1'b0, s[31:0]};
  endfunction

  // ---------------- stage 1: input register ----------------
  logic        s1_v_r;
  fpa_pkg::s1_t s1_r, s1_nxt;

  always_comb begin
    s1_nxt.mode  = in_ch.mode;
    s1_nxt.a     = in_ch.operand_a;
    s1_nxt.b     = in_ch.operand_b;
    s1_nxt.mag_a = in_ch.operand_a[31] ? 32'(-in_ch.operand_a) : in_ch.operand_a;
    s1_nxt.mag_b = in_ch.operand_b[31] ? 32'(-in_ch.operand_b) : in_ch.operand_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------- stage 2: simple ops, multiply ----------------
  logic         s2_v_r;
  fpa_pkg::s2_t s2_r, s2_nxt;
  logic [32:0]  sa;
  logic signed [31:0] itof_hi;

  always_comb begin
    s2_nxt       = '0;
    s2_nxt.mode  = s1_r.mode;
    s2_nxt.prod  = s1_r.mag_a * s1_r.mag_b;
    s2_nxt.neg   = s1_r.a[31] ^ s1_r.b[31];
    s2_nxt.mag_a = s1_r.mag_a;
    s2_nxt.mag_b = s1_r.mag_b;
    sa           = '0;
    itof_hi      = s1_r.a >>> (31 - FRAC_BITS);
    case (s1_r.mode)
      fpa_pkg::MODE_ADD: begin
        sa = sat_add(s1_r.a, s1_r.b);
        {s2_nxt.sat, s2_nxt.res} = sa;
      end
      fpa_pkg::MODE_SUB: begin
        // subtract via 33-bit difference
        sa = {1'b0, 32'(s1_r.a - s1_r.b)};
        if (({s1_r.a[31], s1_r.a} - {s1_r.b[31], s1_r.b}) !=
            {sa[31], sa[31:0]}) begin
          s2_nxt.sat = 1'b1;
          s2_nxt.res = s1_r.a[31] ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
        end else begin
          s2_nxt.res = sa[31:0];
        end
      end
      fpa_pkg::MODE_DIV: begin
        s2_nxt.dz = s1_r.mag_b == '0;
      end
      fpa_pkg::MODE_CMP: begin
        s2_nxt.lt = s1_r.a < s1_r.b;
        s2_nxt.eq = s1_r.a == s1_r.b;
        s2_nxt.gt = s1_r.a > s1_r.b;
      end
      fpa_pkg::MODE_MIN: s2_nxt.res = (s1_r.a < s1_r.b) ? s1_r.a : s1_r.b;
      fpa_pkg::MODE_MAX: s2_nxt.res = (s1_r.a > s1_r.b) ? s1_r.a : s1_r.b;
      fpa_pkg::MODE_INC: begin
        sa = sat_add(s1_r.a, 32'sd1);
        {s2_nxt.sat, s2_nxt.res} = sa;
      end
      fpa_pkg::MODE_DEC: begin
        sa = sat_add(s1_r.a, -32'sd1);
        {s2_nxt.sat, s2_nxt.res} = sa;
      end
      fpa_pkg::MODE_ITOF: begin
        // bits shifted out must all match the sign
        if (!((&itof_hi) || !(|itof_hi))) begin
          s2_nxt.sat = 1'b1;
          s2_nxt.res = s1_r.a[31] ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
        end else begin
          s2_nxt.res = s1_r.a <<< FRAC_BITS;
        end
      end
      fpa_pkg::MODE_FTOI: s2_nxt.res = s1_r.a >>> FRAC_BITS;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------- stage 3: product rounding, divider setup ----------------
  logic          div_v [0:fpa_pkg::DIV_STEPS];
  fpa_pkg::div_t div_d [0:fpa_pkg::DIV_STEPS];
  fpa_pkg::div_t s3_nxt;
  logic [63:0]   mr;
  logic [NW-1:0] num;
  logic          dov;

  always_comb begin
    s3_nxt      = '0;
    s3_nxt.mode = s2_r.mode;
    s3_nxt.res  = s2_r.res;
    s3_nxt.lt   = s2_r.lt;
    s3_nxt.eq   = s2_r.eq;
    s3_nxt.gt   = s2_r.gt;
    s3_nxt.sat  = s2_r.sat;
    s3_nxt.dz   = s2_r.dz;
    s3_nxt.neg  = s2_r.neg;
    s3_nxt.d    = s2_r.mag_b;
    // |a| << F: bits 32 and up must stay below d or the quotient overflows
    num         = NW'(s2_r.mag_a) << FRAC_BITS;
    dov         = 32'(num[NW-1:32]) >= s2_r.mag_b;
    s3_nxt.ovf  = dov;
    s3_nxt.rem  = dov ? '0 : 32'(num[NW-1:32]);
    s3_nxt.lo   = num[31:0];
    // product magnitude, round half away from zero
    mr = (s2_r.prod + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (s2_r.mode == fpa_pkg::MODE_MUL) begin
      if (s2_r.neg) begin
        if (mr > 64'h8000_0000) begin
          s3_nxt.sat = 1'b1;
          s3_nxt.res = fpa_pkg::MIN32;
        end else begin
          s3_nxt.res = 32'(-mr[31:0]);
        end
      end else begin
        if (mr > 64'h7FFF_FFFF) begin
          s3_nxt.sat = 1'b1;
          s3_nxt.res = fpa_pkg::MAX32;
        end else begin
          s3_nxt.res = mr[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v[0] <= 1'b0;
    end else if (en) begin
      div_v[0] <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_d[0] <= s3_nxt;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar i = 0; i < fpa_pkg::DIV_STEPS; i++) begin : g_div
    fpa_div_stage u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (div_v[i]),
      .in_d    (div_d[i]),
      .out_v_r (div_v[i+1]),
      .out_d_r (div_d[i+1])
    );
  end

  // ---------------- final stage: quotient rounding, output register ----------------
  fpa_pkg::div_t dl;
  logic [32:0]   qr;
  logic signed [31:0] res_r, res_nxt;
  logic          lt_r, eq_r, gt_r, sat_r, dz_r;
  logic          sat_nxt;

  assign dl = div_d[fpa_pkg::DIV_STEPS];

  always_comb begin
    res_nxt = dl.res;
    sat_nxt = dl.sat;
    qr      = {1'b0, dl.q} + 33'({dl.rem, 1'b0} >= {1'b0, dl.d});
    if (dl.mode == fpa_pkg::MODE_DIV && !dl.dz) begin
      if (dl.neg) begin
        if (dl.ovf || qr > 33'h0_8000_0000) begin
          sat_nxt = 1'b1;
          res_nxt = fpa_pkg::MIN32;
        end else begin
          res_nxt = 32'(-qr[31:0]);
        end
      end else begin
        if (dl.ovf || qr > 33'h0_7FFF_FFFF) begin
          sat_nxt = 1'b1;
          res_nxt = fpa_pkg::MAX32;
        end else begin
          res_nxt = qr[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= div_v[fpa_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      lt_r  <= dl.lt;
      eq_r  <= dl.eq;
      gt_r  <= dl.gt;
      sat_r <= sat_nxt;
      dz_r  <= dl.dz;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.result         = res_r;
  assign out_ch.is_less        = lt_r;
  assign out_ch.is_equal       = eq_r;
  assign out_ch.is_greater     = gt_r;
  assign out_ch.saturated      = sat_r;
  assign out_ch.divide_by_zero = dz_r;

  // ---------------- checks ----------------
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $onehot0({lt_r, eq_r, gt_r}))
    else $error("compare flags not exclusive");

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && dz_r |-> res_r == '0 && !sat_r)
    else $error("divide by zero result not cleared");

  a_cmp_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (lt_r || eq_r || gt_r) |-> res_r == '0 && !sat_r && !dz_r)
    else $error("compare flags with non-compare result");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(div_v[0]) && $stable(s2_v_r))
    else $error("pipeline moved while stalled");

endmodule

// ----- src/fpa_div_stage.sv -----
module fpa_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  fpa_pkg::div_t in_d,
  output logic          out_v_r,
  output fpa_pkg::div_t out_d_r
);

  logic [32:0]   trial;
  logic          ge;
  fpa_pkg::div_t d_nxt;

  // one restoring step: one quotient bit
  always_comb begin
    trial = {in_d.rem, in_d.lo[31]};
    ge    = trial >= {1'b0, in_d.d};
    d_nxt = in_d;
    d_nxt.rem = ge ? 32'(trial - {1'b0, in_d.d}) : trial[31:0];
    d_nxt.lo  = {in_d.lo[30:0], 1'b0};
    d_nxt.q   = {in_d.q[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= d_nxt;
    end
  end

endmodule
